[sv/gia_pkg.sv]
// Shared types and codes for the generational identifier allocator.
package gia_pkg;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;
   localparam logic [1:0] ST_REJECTED  = 2'd3;

   typedef struct packed {
      logic       op;
      logic       release_has_id;
      logic [7:0] release_id;
   } req_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] generation;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic gen_upd;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic rsp_free;
   } stat_type;

endpackage

[sv/gia_ctrl.sv]
// Sequencing state machine of the generational identifier allocator.
module gia_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gia_pkg::stat_type stat,
   output gia_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_RD,
      S_GEN_UPD,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.pop ? S_POP_RD : S_DONE;
         end
         S_POP_RD: begin
            // The popped identifier is now registered; its generation is read here.
            state_in = S_GEN_UPD;
         end
         S_GEN_UPD: begin
            cmd.gen_upd = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/gia_dpath.sv]
// Counters, free stack, generation table and output register of the allocator.
module gia_dpath #(
   parameter int MAX_IDS   = 256,
   parameter int GEN_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  gia_pkg::req_type  req_data,
   input  gia_pkg::cmd_type  cmd,
   output gia_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gia_pkg::rsp_type  rsp_data
);

   localparam int ID_W  = $clog2(MAX_IDS);
   localparam int CNT_W = $clog2(MAX_IDS + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   logic [ID_W-1:0]      stack_mem [MAX_IDS];
   logic [GEN_WIDTH-1:0] gen_mem   [MAX_IDS];

   gia_pkg::req_type     req_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     fresh_ff, fresh_in;
   logic [ID_W-1:0]      stack_rd_ff;
   logic [GEN_WIDTH-1:0] gen_rd_ff;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [GEN_WIDTH-1:0] res_gen_ff, res_gen_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   gia_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 stack_we;
   logic [ID_W-1:0]      stack_waddr, stack_raddr;
   logic                 gen_we;
   logic [ID_W-1:0]      gen_waddr;
   logic [GEN_WIDTH-1:0] gen_wdata, gen_next;
   logic                 count_empty, count_full, fresh_left, rid_unissued;

   assign count_empty  = (count_ff == '0);
   assign count_full   = (count_ff == CNT_W'(MAX_IDS));
   assign fresh_left   = (fresh_ff != CNT_W'(MAX_IDS));
   assign rid_unissued = (CMP_W'(req_ff.release_id) >= CMP_W'(fresh_ff));
   assign gen_next     = gen_rd_ff + GEN_WIDTH'(1);

   assign stat.pop      = (req_ff.op == gia_pkg::OP_ALLOC) && !count_empty;
   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;

   // The top of the stack is always on the read port, so a pop finds it registered.
   assign stack_raddr = count_empty ? '0 : ID_W'(count_ff - CNT_W'(1));

   always_comb begin
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      res_id_in     = res_id_ff;
      res_gen_in    = res_gen_ff;
      res_status_in = res_status_ff;
      stack_we      = 1'b0;
      stack_waddr   = count_ff[ID_W-1:0];
      gen_we        = 1'b0;
      gen_waddr     = stack_rd_ff;
      gen_wdata     = gen_next;
      if (cmd.exec) begin
         res_id_in     = '0;
         res_gen_in    = '0;
         res_status_in = gia_pkg::ST_OK;
         if (req_ff.op == gia_pkg::OP_ALLOC) begin
            // A pop lowers the count only in the generation update step, so the
            // read port keeps the popped identifier until then.
            if (count_empty && fresh_left) begin
               gen_we    = 1'b1;
               gen_waddr = fresh_ff[ID_W-1:0];
               gen_wdata = '0;
               res_id_in = fresh_ff[ID_W-1:0];
               fresh_in  = fresh_ff + CNT_W'(1);
            end else if (count_empty) begin
               res_status_in = gia_pkg::ST_EXHAUSTED;
            end
         end else if (!req_ff.release_has_id) begin
            res_status_in = gia_pkg::ST_INVALID;
         end else if (rid_unissued || count_full) begin
            res_status_in = gia_pkg::ST_REJECTED;
         end else begin
            stack_we = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.gen_upd) begin
         gen_we     = 1'b1;
         count_in   = count_ff - CNT_W'(1);
         res_id_in  = stack_rd_ff;
         res_gen_in = gen_next;
      end
   end

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         rsp_in.id         = 8'(res_id_ff);
         rsp_in.generation = 16'(res_gen_ff);
         rsp_in.status     = res_status_ff;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= ID_W'(req_ff.release_id);
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_waddr] <= gen_wdata;
      end
      gen_rd_ff <= gen_mem[stack_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      res_id_ff     <= res_id_in;
      res_gen_ff    <= res_gen_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/generational_id_allocator.sv]
// Generational identifier allocator: hands out and takes back identifiers with generations.
//
// Request channel (req_): one beat carries op, release_has_id and release_id.
// An allocate pops the most recently released identifier and bumps its
// generation, or issues the next fresh identifier at generation zero, or
// reports exhaustion. A release pushes a checked identifier onto the free stack.
// Response channel (rsp_): exactly one beat per request, in request order,
// with id, generation and status.
// Timing: one request is in work at a time. A release, a fresh allocate or any
// refused request passes through the execute and done states before the next
// acceptance, with the response loaded in the done state. An allocate that
// reuses an identifier also passes through the pop-read and generation update
// states: the stack top and then that identifier's generation entry are read one
// after the other, each through the registered read port of its memory.
// Reset clears the counters and the response valid flag; both memories start
// undefined and no clearing pass is needed. A stalled response is held in its
// register while the next request is accepted; that request then waits for it.
module generational_id_allocator #(
   parameter int MAX_IDS   = 256,
   parameter int GEN_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gia_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gia_pkg::rsp_type rsp_data
);

   gia_pkg::cmd_type  cmd;
   gia_pkg::stat_type stat;

   gia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   gia_dpath #(
      .MAX_IDS   (MAX_IDS),
      .GEN_WIDTH (GEN_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A captured request is always executed in the following cycle.
   a_capture_exec : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("captured request not executed");

   // A generation update only follows an execute step, with the pop-read state between them.
   a_gen_upd_order : assert property (@(posedge clock) disable iff (reset)
      cmd.gen_upd |-> $past(cmd.exec, 2))
      else $error("generation update out of sequence");

   // No new request is taken while one is still in work.
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // Reset leaves no response pending.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
